[rtl/lps_pkg.sv]
`timescale 1ns / 1ps
package lps_pkg;

	localparam int PCT_W = 14;
	localparam int PCT_SCALE = 10000;
	localparam logic [PCT_W-1:0] PCT_A_RESET = 14'd9500;
	localparam logic [PCT_W-1:0] PCT_B_RESET = 14'd9900;

	// register byte addresses
	localparam logic [2:0] ADDR_PCT_A = 3'd0;
	localparam logic [2:0] ADDR_PCT_B = 3'd4;

	typedef struct packed {
		logic ins;  // insert the broadcast sample in order
		logic shl;  // shift the row one cell toward the head
	} lps_cell_ctrl_t;

endpackage

[rtl/lps_cell.sv]
`timescale 1ns / 1ps
module lps_cell import lps_pkg::*; #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lps_cell_ctrl_t ctrl,
	input  logic [W-1:0]   x,
	input  logic [W-1:0]   prev_val,
	input  logic           prev_vld,
	input  logic           prev_le,
	input  logic [W-1:0]   next_val,
	input  logic           next_vld,
	output logic [W-1:0]   val,
	output logic           vld,
	output logic           le
);

	logic [W-1:0] val_q;
	logic         vld_q;

	assign val = val_q;
	assign vld = vld_q;
	assign le  = vld_q && (val_q <= x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.shl) begin
			vld_q <= next_vld;
		end else if (ctrl.ins) begin
			vld_q <= vld_q | prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shl) begin
			val_q <= next_val;
		end else if (ctrl.ins && !le) begin
			// left neighbor at or below the sample: sample lands here, else make room
			val_q <= prev_le ? x : prev_val;
		end
	end

endmodule

[rtl/lps_div.sv]
`timescale 1ns / 1ps
module lps_div #(
	parameter int NW = 44,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign done  = !busy_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// restoring, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

endmodule

[rtl/latency_percentile_statistics.sv]
`timescale 1ns / 1ps
// Latency percentile statistics over sets of samples.
// Input channel: sample_us with last_sample, valid/stall. While in_stall is
// low, samples are taken one per cycle and inserted in sorted order into
// a row of CAPACITY cells. Samples past CAPACITY are dropped and flagged
// in truncated. The beat with last_sample set closes the set. The block
// then stalls its input while the row shifts its sorted contents out through
// the head cell one per cycle and a serial divider forms the mean one bit
// per cycle; it also waits for any earlier result to be taken.
// One result beat follows with count, mean, median, two percentiles,
// min, max and truncated. The row is left empty by the drain itself.
// The result sits in an output register; the next set may start loading
// while it waits, and a stalled result holds until taken.
// Reset empties the row, clears the count and sum, drops any pending result
// and restores the percentile registers to 95.00 and 99.00 percent.
// Percentile registers sit at byte 0 and 4 of the APB port, 14 bits each.
module latency_percentile_statistics import lps_pkg::*; #(
	parameter int CAPACITY    = 4096,
	parameter int SAMPLE_BITS = 32,
	localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample_us,
	input  logic                   last_sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CNT_W-1:0]       sample_count,
	output logic [SAMPLE_BITS-1:0] mean_us,
	output logic [SAMPLE_BITS-1:0] median_us,
	output logic [SAMPLE_BITS-1:0] pct_a_us,
	output logic [SAMPLE_BITS-1:0] pct_b_us,
	output logic [SAMPLE_BITS-1:0] min_us,
	output logic [SAMPLE_BITS-1:0] max_us,
	output logic                   truncated
);

	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int PW    = PCT_W + CNT_W;
	localparam logic [1:0] S_LOAD  = 2'd0;
	localparam logic [1:0] S_PREP  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_WAIT  = 2'd3;

	logic [1:0]             state_q;
	logic [PCT_W-1:0]       pct_a_q, pct_b_q;
	logic [CNT_W-1:0]       cnt_q, k_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   ovf_q;
	logic [PW-1:0]          pa_q, pb_q;
	logic [PW:0]            acc_q;
	logic [SAMPLE_BITS-1:0] min_q, max_q, pa_val_q, pb_val_q, mid_a_q, mid_b_q;
	logic                   out_valid_q;
	logic [CNT_W-1:0]       o_cnt_q;
	logic [SAMPLE_BITS-1:0] o_mean_q, o_med_q, o_pa_q, o_pb_q, o_min_q, o_max_q;
	logic                   o_trunc_q;

	logic                   in_acc, room, cfg_wr, div_start, div_done, finish;
	logic [SUM_W-1:0]       div_quo;
	logic [PW:0]            acc_hi;
	logic [CNT_W-1:0]       half;
	logic [SAMPLE_BITS:0]   mid_sum;
	lps_cell_ctrl_t         ctrl;

	logic [SAMPLE_BITS-1:0] cval [CAPACITY];
	logic                   cvld [CAPACITY];
	logic                   cle  [CAPACITY];

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		unique case (paddr)
			ADDR_PCT_A: prdata = {{(32-PCT_W){1'b0}}, pct_a_q};
			ADDR_PCT_B: prdata = {{(32-PCT_W){1'b0}}, pct_b_q};
			default:    prdata = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_a_q <= PCT_A_RESET;
			pct_b_q <= PCT_B_RESET;
		end else if (cfg_wr) begin
			if (paddr == ADDR_PCT_A) pct_a_q <= pwdata[PCT_W-1:0];
			if (paddr == ADDR_PCT_B) pct_b_q <= pwdata[PCT_W-1:0];
		end
	end

	assign in_stall  = state_q != S_LOAD;
	assign in_acc    = in_valid && !in_stall;
	assign room      = cnt_q < CNT_W'(CAPACITY);
	assign ctrl.ins  = in_acc && room;
	assign ctrl.shl  = state_q == S_DRAIN;
	assign div_start = state_q == S_PREP;
	assign finish    = state_q == S_WAIT && div_done && !out_valid_q;
	assign half      = cnt_q >> 1;
	assign acc_hi    = acc_q + (PW+1)'(PCT_SCALE);
	assign mid_sum   = {1'b0, mid_a_q} + {1'b0, mid_b_q};

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic [SAMPLE_BITS-1:0] pv, nv;
			logic                   pvl, ple, nvl;
			if (i == 0) begin : g_head
				assign pv  = sample_us;
				assign pvl = 1'b1;
				assign ple = 1'b1;
			end else begin : g_body
				assign pv  = cval[i-1];
				assign pvl = cvld[i-1];
				assign ple = cle[i-1];
			end
			if (i == CAPACITY - 1) begin : g_tail
				assign nv  = '0;
				assign nvl = 1'b0;
			end else begin : g_mid
				assign nv  = cval[i+1];
				assign nvl = cvld[i+1];
			end
			lps_cell #(.W(SAMPLE_BITS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.x        (sample_us),
				.prev_val (pv),
				.prev_vld (pvl),
				.prev_le  (ple),
				.next_val (nv),
				.next_vld (nvl),
				.val      (cval[i]),
				.vld      (cvld[i]),
				.le       (cle[i])
			);
		end
	endgenerate

	lps_div #(.NW(SUM_W), .DW(CNT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_q),
		.den    (cnt_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
							sum_q <= sum_q + SUM_W'(sample_us);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_sample) state_q <= S_PREP;
					end
				end
				S_PREP: begin
					k_q     <= '0;
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					k_q <= k_q + 1'b1;
					if (k_q == cnt_q - 1'b1) state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (finish) begin
						out_valid_q <= 1'b1;
						cnt_q       <= '0;
						sum_q       <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// drain datapath: head cell gives sorted[k] each cycle
	always_ff @(posedge clk) begin
		if (state_q == S_PREP) begin
			pa_q  <= PW'(pct_a_q * cnt_q);
			pb_q  <= PW'(pct_b_q * cnt_q);
			acc_q <= '0;
		end
		if (state_q == S_DRAIN) begin
			acc_q <= acc_hi;
			if (k_q == '0) min_q <= cval[0];
			if (k_q == cnt_q - 1'b1) max_q <= cval[0];
			if (k_q == half - 1'b1) mid_a_q <= cval[0];
			if (k_q == half) mid_b_q <= cval[0];
			// index k where k*scale <= p*n < (k+1)*scale, clamped to the last
			if ({1'b0, pa_q} >= acc_q && ({1'b0, pa_q} < acc_hi || k_q == cnt_q - 1'b1))
				pa_val_q <= cval[0];
			if ({1'b0, pb_q} >= acc_q && ({1'b0, pb_q} < acc_hi || k_q == cnt_q - 1'b1))
				pb_val_q <= cval[0];
		end
		if (finish) begin
			o_cnt_q   <= cnt_q;
			o_mean_q  <= div_quo[SAMPLE_BITS-1:0];
			o_med_q   <= cnt_q[0] ? mid_b_q : mid_sum[SAMPLE_BITS:1];
			o_pa_q    <= pa_val_q;
			o_pb_q    <= pb_val_q;
			o_min_q   <= min_q;
			o_max_q   <= max_q;
			o_trunc_q <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_count = o_cnt_q;
	assign mean_us      = o_mean_q;
	assign median_us    = o_med_q;
	assign pct_a_us     = o_pa_q;
	assign pct_b_us     = o_pb_q;
	assign min_us       = o_min_q;
	assign max_us       = o_max_q;
	assign truncated    = o_trunc_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("sample count past capacity");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |-> cvld[0])
		else $error("drain read an empty head cell");

	a_row_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD && cvld[1] |-> cval[0] <= cval[1])
		else $error("row out of order");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PREP |-> cnt_q != '0)
		else $error("set closed with no kept sample");

	a_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WAIT |-> !cvld[0])
		else $error("row not emptied by drain");

endmodule
